FILE: rtl/swm_pkg.sv
// sliding window maximum: shared constants and helpers
// no dependencies; imported by the cell and the top level
package swm_pkg;

  // configuration register width and its value after reset
  localparam int unsigned CfgWidth = 7;
  localparam logic [CfgWidth-1:0] WinSizeRst = 7'd3;

  // larger of two signed samples
  function automatic logic signed [63:0] smax64(logic signed [63:0] a, logic signed [63:0] b);
    return (a >= b) ? a : b;
  endfunction

endpackage

FILE: rtl/swm_cell.sv
// sliding window maximum: one cell of the running-maximum row
// depends on swm_pkg; instantiated by sliding_window_maximum
module swm_cell import swm_pkg::*; #(
  parameter int unsigned SampleWidth = 32
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic signed [SampleWidth-1:0] sample_i,
  input  logic signed [SampleWidth-1:0] prev_i,
  output logic signed [SampleWidth-1:0] max_o
);

  logic signed [SampleWidth-1:0] max_d, max_q;

  // max of the new sample and the neighbor's span one sample shorter
  always_comb begin
    max_d = SampleWidth'(smax64(64'(sample_i), 64'(prev_i)));
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      max_q <= max_d;
    end
  end

  assign max_o = max_q;

endmodule

FILE: rtl/sliding_window_maximum.sv
// sliding window maximum over a signed sample stream
// a result is registered in the output register when its sample is accepted
// throughput: one sample per cycle while the output is not stalled; the row of compare cells updates all at once
// reset: window size 3, sample count cleared, output register empty
// depends on swm_pkg and swm_cell
module sliding_window_maximum import swm_pkg::*; #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [CfgWidth-1:0]            cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           stream_start_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] window_max_o
);

  localparam int unsigned CntW = $clog2(WINDOW_MAX + 1);
  localparam int unsigned IdxW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [CfgWidth-1:0]           win_size_q;
  logic [CntW-1:0]               k_len, tap_full, seen_base;
  logic [IdxW-1:0]               tap_idx;
  logic [CntW-1:0]               seen_d, seen_q;
  logic                          in_fire, res_d;
  logic                          out_valid_d, out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_data_d, out_data_q, tap_val;
  logic signed [SAMPLE_WIDTH-1:0] cell_max [WINDOW_MAX];

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_size_q <= WinSizeRst;
    end else if (cfg_we_i) begin
      win_size_q <= cfg_wdata_i;
    end
  end

  // window length clamped to one through the row length
  always_comb begin
    if (win_size_q == '0) begin
      k_len = CntW'(1);
    end else if (int'(win_size_q) > int'(WINDOW_MAX)) begin
      k_len = CntW'(WINDOW_MAX);
    end else begin
      k_len = CntW'(win_size_q);
    end
  end

  // request handshake, output register parts the two sides
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // row of cells: cell i holds the max of the last i+1 samples
  for (genvar gi = 0; gi < WINDOW_MAX; gi++) begin : g_cell
    logic signed [SAMPLE_WIDTH-1:0] prev;
    if (gi == 0) begin : g_head
      assign prev = sample_i;
    end else begin : g_link
      assign prev = cell_max[gi-1];
    end
    swm_cell #(
      .SampleWidth(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .en_i    (in_fire),
      .sample_i(sample_i),
      .prev_i  (prev),
      .max_o   (cell_max[gi])
    );
  end

  // window max: new sample against the cell covering the older k-1 samples
  assign tap_full = k_len - CntW'(2);
  assign tap_idx  = tap_full[IdxW-1:0];
  assign tap_val  = cell_max[tap_idx];

  always_comb begin
    if (k_len == CntW'(1)) begin
      out_data_d = sample_i;
    end else begin
      out_data_d = SAMPLE_WIDTH'(smax64(64'(sample_i), 64'(tap_val)));
    end
  end

  // stream sample count, saturating at the window length
  always_comb begin
    seen_base = stream_start_i ? '0 : seen_q;
    if (seen_base < k_len) begin
      seen_d = seen_base + CntW'(1);
    end else begin
      seen_d = k_len;
    end
    res_d = (seen_d == k_len);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (in_fire) begin
      seen_q <= seen_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = res_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign window_max_o = out_data_q;

`ifndef SYNTHESIS
  a_seen_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(seen_q) <= int'(WINDOW_MAX))
    else $error("sample count beyond row length");

  a_fire_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> seen_q != '0)
    else $error("accepted sample not counted");

  a_start_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && stream_start_i && k_len != CntW'(1) |=> !out_valid_q)
    else $error("result on first sample of a longer window");

  a_unit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && k_len == CntW'(1) |=> out_valid_q && out_data_q == $past(sample_i))
    else $error("unit window must echo the sample");
`endif

endmodule
